/* rtl/cpcm_pkg.sv */
package cpcm_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 18;

    localparam int CW     = 32;
    localparam int SQW    = CW + 1;
    localparam int RADW   = 2 * SQW;
    localparam int REMW   = SQW + 4;
    localparam int QW     = FRAC_BITS + 4;
    localparam int NUMW   = CW + FRAC_BITS;
    localparam int DW     = SQW + QW - 1;
    localparam int ANGW   = FRAC_BITS + 2;
    localparam int ANG_FRAC = 30;
    localparam int ANG_SH = ANG_FRAC - FRAC_BITS;
    localparam int XW     = CW + 4;
    localparam int ZW     = ANG_FRAC + 4;
    localparam int IDXW   = $clog2(CORDIC_STAGES);
    localparam int LATENCY = 5 + SQW + QW;
    localparam int ADLY   = LATENCY - 3 - CORDIC_STAGES;

    localparam logic [ZW-1:0] PI_Q30      = ZW'(64'd3373259426);
    localparam logic [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);
    localparam logic [QW-1:0] ONE_Q       = QW'(64'd1 << FRAC_BITS);
    localparam logic [QW-1:0] SAT_Q       = QW'(64'd9 << FRAC_BITS);
    localparam logic [QW-1:0] RAD_SAT     = QW'(64'd1 << (QW - 1));
    localparam logic [ANGW-1:0] PI_OUT    =
        ANGW'((64'd3373259426 + (64'd1 << (ANG_SH - 1))) >> ANG_SH);

    typedef enum logic [1:0] {
        A_NORM,
        A_ZERO,
        A_PI,
        A_HALF
    } t_aspec;

    typedef struct packed {
        logic            vld;
        logic [RADW-1:0] rad;
        logic [REMW-1:0] rem;
        logic [SQW-1:0]  root;
    } t_sq;

    typedef struct packed {
        logic            vld;
        logic [NUMW-1:0] rem;
        logic [DW-1:0]   dsh;
        logic [QW-1:0]   q;
        logic            ovf;
        logic [SQW-1:0]  root;
    } t_dv;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        t_aspec               spec;
    } t_cor;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [IDXW-1:0] i);
        logic [31:0] v;
        case (5'(i))
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            5'd24: v = 32'd64;
            5'd25: v = 32'd32;
            5'd26: v = 32'd16;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return $signed({{(ZW-32){1'b0}}, v});
    endfunction

endpackage

/* rtl/cpcm_sqrt_cell.sv */
module cpcm_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cpcm_pkg::t_sq i_d,
    output cpcm_pkg::t_sq o_d
);
    import cpcm_pkg::*;

    t_sq             r_d;
    t_sq             n_d;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;

    always_comb begin
        rem_sh    = {i_d.rem[REMW-3:0], i_d.rad[RADW-1 -: 2]};
        trial     = {2'b00, i_d.root, 2'b01};
        n_d.vld   = i_d.vld;
        n_d.rad   = {i_d.rad[RADW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_d.rem  = rem_sh - trial;
            n_d.root = {i_d.root[SQW-2:0], 1'b1};
        end else begin
            n_d.rem  = rem_sh;
            n_d.root = {i_d.root[SQW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* rtl/cpcm_div_cell.sv */
module cpcm_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cpcm_pkg::t_dv i_d,
    output cpcm_pkg::t_dv o_d
);
    import cpcm_pkg::*;

    t_dv           r_d;
    t_dv           n_d;
    logic [DW-1:0] rem_x;
    logic          ge;

    always_comb begin
        rem_x    = DW'(i_d.rem);
        ge       = rem_x >= i_d.dsh;
        n_d      = i_d;
        n_d.dsh  = i_d.dsh >> 1;
        n_d.q    = {i_d.q[QW-2:0], ge};
        n_d.rem  = ge ? NUMW'(rem_x - i_d.dsh) : i_d.rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* rtl/cpcm_cordic_cell.sv */
module cpcm_cordic_cell (
    input  logic                      i_clk,
    input  logic [cpcm_pkg::IDXW-1:0] i_idx,
    input  cpcm_pkg::t_cor            i_d,
    output cpcm_pkg::t_cor            o_d
);
    import cpcm_pkg::*;

    t_cor                 r_d;
    t_cor                 n_d;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] at;

    always_comb begin
        xs       = i_d.x >>> i_idx;
        ys       = i_d.y >>> i_idx;
        at       = atan_q30(i_idx);
        n_d.spec = i_d.spec;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + at;
        end else begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule

/* rtl/compact_polar_coordinate_mapper.sv */
// Compact polar coordinate mapper.
// Command channel: a point (i_x_coord, i_z_coord, signed Q16.16) is taken
// at a clock edge with start high and busy low. busy is high only in
// reset and the cycle after it, so a new point may follow every cycle.
// Result channel: o_valid marks one cycle carrying o_radial_coord
// (1 - 2*rmin/r, Q3.16, saturates at -8), o_polar_angle (Q2.16 radians,
// 0..pi) and o_inside_res. The receiver cannot stall; one word comes out
// per point, in order.
// Each point passes stages A, B and C, the 33-cell square-root row, the
// divider set-up register, the 20-cell divider row and the output
// register. The 18-cell CORDIC row runs alongside and its angle waits
// in a delay line. Throughput: one point per cycle.
// Configuration by APB at 0x0 center_x, 0x4 center_z, 0x8 inner_radius,
// 0xC tolerance; write only while no point is in flight.
// Reset (synchronous, active low) empties the pipeline and restores
// center 0, inner radius 1.0 and tolerance 0.
module compact_polar_coordinate_mapper (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         i_x_coord,
    input  logic signed [31:0]         i_z_coord,
    output logic                       o_valid,
    output logic signed [cpcm_pkg::QW-1:0]  o_radial_coord,
    output logic [cpcm_pkg::ANGW-1:0]  o_polar_angle,
    output logic                       o_inside_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cpcm_pkg::*;

    typedef enum logic [1:0] {
        REG_CX,
        REG_CZ,
        REG_RMIN,
        REG_TOL
    } t_reg;

    logic              r_busy;
    logic [31:0]       r_cx;
    logic [31:0]       r_cz;
    logic [30:0]       r_rmin;
    logic [30:0]       r_tol;
    logic              wr;
    t_reg              sel;

    assign pready = 1'b1;
    assign busy   = r_busy;
    assign wr     = psel & penable & pwrite;
    assign sel    = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cx   <= '0;
            r_cz   <= '0;
            r_rmin <= 31'd65536;
            r_tol  <= '0;
        end else begin
            r_busy <= 1'b0;
            if (wr) begin
                unique case (sel)
                    REG_CX:   r_cx   <= pwdata;
                    REG_CZ:   r_cz   <= pwdata;
                    REG_RMIN: r_rmin <= pwdata[30:0];
                    REG_TOL:  r_tol  <= pwdata[30:0];
                    default:  r_tol  <= r_tol;
                endcase
            end
        end
    end

    always_comb begin
        unique case (sel)
            REG_CX:   prdata = r_cx;
            REG_CZ:   prdata = r_cz;
            REG_RMIN: prdata = {1'b0, r_rmin};
            REG_TOL:  prdata = {1'b0, r_tol};
            default:  prdata = '0;
        endcase
    end

    // stage A: offsets from the centre
    logic                  r_a_vld;
    logic signed [SQW-1:0] r_dx;
    logic signed [SQW-1:0] r_dz;

    always_ff @(posedge i_clk) begin
        r_dx    <= $signed({i_x_coord[31], i_x_coord}) - $signed({r_cx[31], r_cx});
        r_dz    <= $signed({i_z_coord[31], i_z_coord}) - $signed({r_cz[31], r_cz});
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start & ~r_busy;
        end
    end

    logic [SQW-1:0] dx_abs;
    logic [SQW-1:0] dz_abs;
    logic [CW-1:0]  ax;
    logic [CW-1:0]  az;

    assign dx_abs = r_dx[SQW-1] ? SQW'(-r_dx) : SQW'(r_dx);
    assign dz_abs = r_dz[SQW-1] ? SQW'(-r_dz) : SQW'(r_dz);
    assign ax     = dx_abs[CW-1:0];
    assign az     = dz_abs[CW-1:0];

    // stage B: squares
    logic              r_b_vld;
    logic [2*CW-1:0]   r_sx;
    logic [2*CW-1:0]   r_sz;

    always_ff @(posedge i_clk) begin
        r_sx    <= ax * ax;
        r_sz    <= az * az;
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    // stage C: sum of squares, head of the square-root row
    t_sq s_sq [0:SQW];
    t_sq r_c;

    always_ff @(posedge i_clk) begin
        r_c.rad  <= RADW'(r_sx) + RADW'(r_sz);
        r_c.rem  <= '0;
        r_c.root <= '0;
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else begin
            r_c.vld <= r_b_vld;
        end
    end

    assign s_sq[0] = r_c;

    for (genvar k = 0; k < SQW; k++) begin : g_sq
        cpcm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (s_sq[k]),
            .o_d     (s_sq[k+1])
        );
    end

    // divider set-up
    t_dv                  s_dv [0:QW];
    t_dv                  r_p;
    logic [SQW-1:0]       root;
    logic [NUMW-1:0]      num;
    logic [SQW+QW-1:0]    rq;

    assign root = s_sq[SQW].root;
    assign num  = {r_rmin, 1'b0, {FRAC_BITS{1'b0}}};
    assign rq   = {root, {QW{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_p.rem  <= num;
        r_p.dsh  <= {root, {(QW-1){1'b0}}};
        r_p.q    <= '0;
        r_p.ovf  <= (root == '0) || ((SQW+QW)'(num) >= rq);
        r_p.root <= root;
        if (!i_rst_n) begin
            r_p.vld <= 1'b0;
        end else begin
            r_p.vld <= s_sq[SQW].vld;
        end
    end

    assign s_dv[0] = r_p;

    for (genvar k = 0; k < QW; k++) begin : g_dv
        cpcm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (s_dv[k]),
            .o_d     (s_dv[k+1])
        );
    end

    // angle path
    t_cor s_co [0:CORDIC_STAGES];
    t_cor r_ci;
    t_cor n_ci;

    always_comb begin
        n_ci.spec = A_NORM;
        if (ax == '0) begin
            n_ci.spec = r_dz[SQW-1] ? A_PI : A_ZERO;
        end else if (r_dz == '0) begin
            n_ci.spec = A_HALF;
        end
        if (r_dz[SQW-1]) begin
            n_ci.x = $signed(XW'(ax));
            n_ci.y = $signed(XW'(dz_abs));
            n_ci.z = HALF_PI_Q30;
        end else begin
            n_ci.x = $signed(XW'(dz_abs));
            n_ci.y = $signed(XW'(ax));
            n_ci.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ci <= n_ci;
    end

    assign s_co[0] = r_ci;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_co
        cpcm_cordic_cell u_cell (
            .i_clk (i_clk),
            .i_idx (IDXW'(k)),
            .i_d   (s_co[k]),
            .o_d   (s_co[k+1])
        );
    end

    logic [ZW-1:0]   z_cl;
    logic [ZW-1:0]   z_rnd;
    logic [ANGW-1:0] ang;

    always_comb begin
        case (s_co[CORDIC_STAGES].spec)
            A_ZERO: z_cl = '0;
            A_PI:   z_cl = PI_Q30;
            A_HALF: z_cl = HALF_PI_Q30;
            default: begin
                if (s_co[CORDIC_STAGES].z < 0) begin
                    z_cl = '0;
                end else if (s_co[CORDIC_STAGES].z > $signed(PI_Q30)) begin
                    z_cl = PI_Q30;
                end else begin
                    z_cl = s_co[CORDIC_STAGES].z;
                end
            end
        endcase
        z_rnd = z_cl + ZW'(64'd1 << (ANG_SH - 1));
        ang   = ANGW'(z_rnd >> ANG_SH);
    end

    logic [ANGW-1:0] r_adly [0:ADLY-1];

    always_ff @(posedge i_clk) begin
        r_adly[0] <= ang;
        for (int k = 1; k < ADLY; k++) begin
            r_adly[k] <= r_adly[k-1];
        end
    end

    // output word
    t_dv                    dv;
    logic signed [SQW:0]    thr;
    logic                   sat;
    logic                   r_o_vld;
    logic [QW-1:0]          r_rad;
    logic [ANGW-1:0]        r_ang;
    logic                   r_in;

    assign dv  = s_dv[QW];
    assign thr = $signed({3'b000, r_rmin}) - $signed({3'b000, r_tol});
    assign sat = dv.ovf || (dv.q > SAT_Q);

    always_ff @(posedge i_clk) begin
        r_rad   <= sat ? RAD_SAT : (ONE_Q - dv.q);
        r_ang   <= r_adly[ADLY-1];
        r_in    <= (thr <= 0) || ($signed({1'b0, dv.root}) >= thr);
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= dv.vld;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_radial_coord = $signed(r_rad);
    assign o_polar_angle  = r_ang;
    assign o_inside_res   = r_in;

endmodule

/* rtl/cpcm_checker.sv */
module cpcm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic signed [cpcm_pkg::QW-1:0]  o_radial_coord,
    input logic [cpcm_pkg::ANGW-1:0]       o_polar_angle,
    input logic                            o_inside_res
);
    import cpcm_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("word after reset");

    a_rad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_radial_coord <= $signed(ONE_Q)))
        else $error("radial out of range");

    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_polar_angle <= PI_OUT))
        else $error("angle beyond pi");

    a_in_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_res) |-> (o_radial_coord < 0))
        else $error("outside point with non-negative radial");

endmodule

bind compact_polar_coordinate_mapper cpcm_checker u_cpcm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .o_radial_coord (o_radial_coord),
    .o_polar_angle  (o_polar_angle),
    .o_inside_res   (o_inside_res)
);

/* sim/cpcm_checker.sv */
module cpcm_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [31:0]                i_x_coord,
    input  logic signed [31:0]                i_z_coord,
    input  logic                              o_valid,
    input  logic signed [cpcm_pkg::QW-1:0]    o_radial_coord,
    input  logic [cpcm_pkg::ANGW-1:0]         o_polar_angle,
    input  logic                              o_inside_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    output int                                n_fail,
    output int                                n_pending,
    output int                                n_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import cpcm_pkg::*;

    localparam logic [3:0] A_CX  = 4'h0;
    localparam logic [3:0] A_CZ  = 4'h4;
    localparam logic [3:0] A_RIN = 4'h8;
    localparam logic [3:0] A_TOL = 4'hC;

    typedef struct packed {
        logic [QW-1:0]   rad;
        logic [ANGW-1:0] ang;
        logic            ins;
    } t_polar;

    t_polar polar_q[$];
    longint cx, cz, rin, tol;

    longint atan_tab[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0};

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [65:0] root66(logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] res;
        logic [67:0] trial;
        rem = 0;
        res = 0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | 68'(v[2*k +: 2]);
            trial = (res << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                res = (res << 1) | 68'd1;
            end else begin
                res = res << 1;
            end
        end
        return res[65:0];
    endfunction

    function automatic longint polar_angle_q30(longint rho, longint dz);
        longint x, y, z, t;
        if (rho == 0) return (dz >= 0) ? 0 : 64'd3373259426;
        if (dz == 0) return 64'd1686629713;
        if (dz < 0) begin
            x = rho; y = -dz; z = 64'd1686629713;
        end else begin
            x = dz; y = rho; z = 0;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            t = x;
            if (y > 0) begin
                x = x + fshr(y, i); y = y - fshr(t, i); z += atan_tab[i];
            end else begin
                x = x - fshr(y, i); y = y + fshr(t, i); z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 64'd3373259426) z = 64'd3373259426;
        return z;
    endfunction

    function automatic t_polar map_point(logic signed [31:0] xc, logic signed [31:0] zc);
        t_polar p;
        longint dx, dz, ax, az, thr, rad, one, ang;
        logic [65:0] sq;
        logic [65:0] r;
        logic [79:0] q;
        dx = longint'(xc) - cx;
        dz = longint'(zc) - cz;
        ax = dx < 0 ? -dx : dx;
        az = dz < 0 ? -dz : dz;
        sq = 66'(ax) * 66'(ax) + 66'(az) * 66'(az);
        r = root66(sq);
        one = 64'd1 << FRAC_BITS;
        if (r == 0) begin
            rad = -8 * one;
        end else begin
            q = (80'(2 * rin) << FRAC_BITS) / 80'(r);
            if (q > 80'(9 * one)) rad = -8 * one;
            else rad = one - longint'(q);
        end
        ang = polar_angle_q30(ax, dz);
        ang = (ang + (64'd1 << (ANG_SH - 1))) >>> ANG_SH;
        thr = rin - tol;
        p.rad = QW'(rad);
        p.ang = ANGW'(ang);
        p.ins = (thr <= 0 || longint'(r) >= thr);
        return p;
    endfunction

    int n_mis;
    t_polar exp_w;

    assign n_pending = polar_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cx <= 0; cz <= 0; rin <= 65536; tol <= 0;
            polar_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    A_CX:  cx <= longint'($signed(pwdata));
                    A_CZ:  cz <= longint'($signed(pwdata));
                    A_RIN: rin <= longint'(pwdata[30:0]);
                    A_TOL: tol <= longint'(pwdata[30:0]);
                    default: ;
                endcase
            end
            if (start && !busy) polar_q.push_back(map_point(i_x_coord, i_z_coord));
            if (o_valid) begin
                n_words++;
                if (polar_q.size() == 0) begin
                    n_fail++;
                    if (n_mis++ < 10) $display("unexpected word rad=%h ang=%h in=%b",
                        o_radial_coord, o_polar_angle, o_inside_res);
                end else begin
                    exp_w = polar_q.pop_front();
                    if (exp_w.rad !== o_radial_coord || exp_w.ang !== o_polar_angle ||
                        exp_w.ins !== o_inside_res) begin
                        n_fail++;
                        if (n_mis++ < 10)
                            $display("mismatch: exp rad=%h ang=%h in=%b got rad=%h ang=%h in=%b",
                                exp_w.rad, exp_w.ang, exp_w.ins,
                                o_radial_coord, o_polar_angle, o_inside_res);
                    end
                end
            end
        end
    end

    initial begin
        n_fail = 0;
        n_mis = 0;
        n_words = 0;
    end
endmodule

/* sim/tb_compact_polar_coordinate_mapper.sv */
module tb_compact_polar_coordinate_mapper;
    timeunit 1ns;
    timeprecision 1ps;
    import cpcm_pkg::*;

    localparam logic [3:0] A_CX  = 4'h0;
    localparam logic [3:0] A_CZ  = 4'h4;
    localparam logic [3:0] A_RIN = 4'h8;
    localparam logic [3:0] A_TOL = 4'hC;
    localparam int WD_LIMIT = 2000;

    logic i_clk = 0, i_rst_n = 0, start = 0;
    logic busy;
    logic signed [31:0] i_x_coord = 0, i_z_coord = 0;
    logic o_valid;
    logic signed [QW-1:0] o_radial_coord;
    logic [ANGW-1:0] o_polar_angle;
    logic o_inside_res;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    int n_fail, n_pending, n_words, n_points, idle_cyc;

    always #5 i_clk = ~i_clk;

    compact_polar_coordinate_mapper dut (.*);
    cpcm_scoreboard u_chk (.*);

    always @(posedge i_clk) begin
        if (start && !busy || o_valid || psel) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc > WD_LIMIT) begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    task automatic reg_write(logic [3:0] a, logic [31:0] d);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (n_pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] z, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start <= 1; i_x_coord <= x; i_z_coord <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_points++;
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 20) << 16;
            2: return 32'($signed($urandom_range(0, 600000)) - 300000);
            default: return {{16{$urandom_range(0,1) == 1}}, 16'($urandom)};
        endcase
    endfunction

    task automatic config_set(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
        reg_write(A_CX, a);
        reg_write(A_CZ, b);
        reg_write(A_RIN, c);
        reg_write(A_TOL, d);
    endtask

    initial begin
        n_points = 0;
        idle_cyc = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, axes, centre, behind centre
        send_point(0, 0, 0);
        send_point(32'h7FFFFFFF, 0, 0);
        send_point(32'h80000000, 0, 0);
        send_point(0, 32'h7FFFFFFF, 0);
        send_point(0, 32'h80000000, 0);
        send_point(32'h80000000, 32'h80000000, 0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        send_point(32'h00010000, 32'hFFFF0000, 0);
        send_point(32'hFFFF0000, 32'h00010000, 0);
        send_point(32'h00008000, 0, 0);
        send_point(0, 32'h00010000, 0);
        send_point(1, 1, 0);
        send_point(32'h0000FFFF, 0, 0);
        send_point(32'h00002000, 0, 0);
        send_point(32'h00001C72, 0, 0);
        start <= 0;
        drain();
        config_set(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h7FFFFFFF, 0);
        send_point(32'h7FFFFFFF, 32'h80000000, 0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        start <= 0;
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: config_set(0, 0, 1, 0);
                1: config_set($urandom, $urandom, $urandom_range(1, 32'h7FFFFFFF),
                              $urandom_range(0, 32'h7FFFFFFF));
                2: config_set(32'h80000000, 32'h7FFFFFFF, 32'h00030000, 32'h00010000);
                3: config_set($urandom_range(0, 20) << 16, $urandom_range(0, 20) << 16,
                              $urandom_range(1, 10) << 16, $urandom_range(0, 3) << 16);
                4: config_set(0, 0, 32'h00010000, 0);
                default: config_set(32'h00050000, 32'hFFFB0000, 32'h00020000, 32'h00050000);
            endcase
            for (int i = 0; i < 195; i++) send_point(rnd_coord(), rnd_coord(), ph < 5);
            start <= 0;
            drain();
        end
        $display("%0d points in 8 register settings, %0d words checked", n_points, n_words);
        if (n_fail == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
